[hw/rtl/soft_travel_limit_table_assert.svh]
// Assertion macros for the soft travel limit table.
// Included by the modules that check their own logic; needs nothing else.
`ifndef SOFT_TRAVEL_LIMIT_TABLE_ASSERT_SVH
`define SOFT_TRAVEL_LIMIT_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define STLT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define STLT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/stlt_pkg.sv]
// Types and constants for the soft travel limit table.
// No dependencies.
package stlt_pkg;

    typedef enum logic [1:0] {
        KIND_TOGGLE = 2'd0,
        KIND_SET    = 2'd1,
        KIND_REBASE = 2'd2,
        KIND_QUERY  = 2'd3
    } kind_t;

    // Limit slots
    localparam logic [1:0] LIM_Z_MIN = 2'd0;
    localparam logic [1:0] LIM_X_MAX = 2'd1;
    localparam logic [1:0] LIM_Z_MAX = 2'd2;
    localparam logic [1:0] LIM_X_MIN = 2'd3;

    // Position marker codes
    localparam logic [2:0] MARK_NONE    = 3'd0;
    localparam logic [2:0] MARK_X_REAR  = 3'd1;
    localparam logic [2:0] MARK_X_FRONT = 3'd2;
    localparam logic [2:0] MARK_Z_LEFT  = 3'd3;
    localparam logic [2:0] MARK_Z_RIGHT = 3'd4;

    // Bounds reported for a limit that is off
    localparam logic signed [31:0] OFF_MIN = -32'sd2000000;
    localparam logic signed [31:0] OFF_MAX = 32'sd2000000;

endpackage

[hw/rtl/soft_travel_limit_table.sv]
// Soft travel limit table, top level.
// Depends on stlt_pkg and soft_travel_limit_table_assert.svh.
//
// Usage:
//   Command channel: drive the item fields and pulse start; the item is taken
//   at any rising edge with start high and busy low. busy is always low, so
//   an item may be given in every cycle.
//   Result channel: done is high for exactly one cycle with all result
//   fields valid; the receiver must take it then, it cannot stall the block.
//   An item taken at a rising edge is registered in the input register;
//   its update and reports are computed from it and registered in the
//   result register together with done. Throughput is one item per cycle;
//   the limit registers are updated in the same pass that produces the
//   result, so back-to-back items see each other's updates in order.
//   Reset: all four limits are off and hold zero; no result is pending.
//   Positions are kept at POSITION_BITS bits signed; results report the
//   low 32 bits.
`include "soft_travel_limit_table_assert.svh"

module soft_travel_limit_table #(
    parameter int POSITION_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         kind,
    input  logic [1:0]         limit_index,
    input  logic               axis_select,
    input  logic               is_max,
    input  logic signed [31:0] position_value,
    input  logic signed [31:0] x_position,
    input  logic signed [31:0] z_position,
    input  logic signed [1:0]  direction,
    output logic               done,
    output logic               accepted,
    output logic [3:0]         led_mask,
    output logic               in_range,
    output logic signed [31:0] clamped_target,
    output logic signed [31:0] axis_min,
    output logic signed [31:0] axis_max,
    output logic               axis_any_active,
    output logic [2:0]         marker,
    output logic signed [31:0] index_target,
    output logic               dir_ok,
    output logic [1:0]         dir_index,
    output logic signed [31:0] dir_target
);

    localparam int P  = POSITION_BITS;
    localparam int CW = (POSITION_BITS > 32) ? POSITION_BITS : 32;

    localparam logic signed [CW-1:0] OFF_MIN_W = CW'(stlt_pkg::OFF_MIN);
    localparam logic signed [CW-1:0] OFF_MAX_W = CW'(stlt_pkg::OFF_MAX);

    function automatic logic signed [CW-1:0] to_cw(input logic signed [P-1:0] v);
        to_cw = CW'(v);
    endfunction

    // Input register
    logic                   valid_reg;
    stlt_pkg::kind_t        kind_reg;
    logic [1:0]             idx_reg;
    logic                   z_reg;
    logic                   is_max_reg;
    logic signed [31:0]     val_in_reg;
    logic signed [31:0]     xp_in_reg;
    logic signed [31:0]     zp_in_reg;
    logic signed [1:0]      dir_reg;

    // Limit state
    logic [3:0]             limit_on_reg;
    logic signed [P-1:0]    limit_value_reg [4];
    logic [3:0]             limit_on_next;
    logic signed [P-1:0]    limit_value_next [4];

    // Result register
    logic                   done_reg;
    logic                   accepted_reg;
    logic [3:0]             led_mask_reg;
    logic                   in_range_reg;
    logic signed [31:0]     clamped_reg;
    logic signed [31:0]     axis_min_reg;
    logic signed [31:0]     axis_max_reg;
    logic                   any_active_reg;
    logic [2:0]             marker_reg;
    logic signed [31:0]     index_target_reg;
    logic                   dir_ok_reg;
    logic [1:0]             dir_index_reg;
    logic signed [31:0]     dir_target_reg;

    // Working signals
    logic signed [63:0]     val_ext;
    logic signed [63:0]     xp_ext;
    logic signed [63:0]     zp_ext;
    logic signed [P-1:0]    val_p;
    logic signed [P-1:0]    xp_p;
    logic signed [P-1:0]    zp_p;
    logic signed [P-1:0]    cap_pos;
    logic signed [P-1:0]    apos;
    logic                   cap_ok;
    logic                   accepted_next;
    logic [1:0]             set_idx;
    logic [1:0]             min_idx;
    logic [1:0]             max_idx;
    logic signed [CW-1:0]   val_cw;
    logic signed [CW-1:0]   xp_cw;
    logic signed [CW-1:0]   zp_cw;
    logic signed [CW-1:0]   x_min_cw;
    logic signed [CW-1:0]   x_max_cw;
    logic signed [CW-1:0]   z_min_cw;
    logic signed [CW-1:0]   z_max_cw;
    logic signed [CW-1:0]   mn_cw;
    logic signed [CW-1:0]   mx_cw;
    logic signed [CW-1:0]   clamped_cw;
    logic signed [CW-1:0]   index_cw;
    logic signed [CW-1:0]   dtgt_cw;
    logic                   in_range_next;
    logic [2:0]             marker_next;
    logic                   dir_up;
    logic                   dir_ok_next;
    logic [1:0]             dir_index_next;
    logic signed [P-1:0]    dtgt_p;

    assign busy = 1'b0;

    // Bring the 32-bit inputs to position width
    assign val_ext = 64'(val_in_reg);
    assign xp_ext  = 64'(xp_in_reg);
    assign zp_ext  = 64'(zp_in_reg);
    assign val_p   = val_ext[P-1:0];
    assign xp_p    = xp_ext[P-1:0];
    assign zp_p    = zp_ext[P-1:0];

    // Toggle captures the position of the limit's own axis
    assign cap_pos = idx_reg[0] ? xp_p : zp_p;

    always_comb
    begin
        unique case (idx_reg)
            stlt_pkg::LIM_Z_MIN:
                cap_ok = !(limit_on_reg[stlt_pkg::LIM_Z_MAX] &&
                           cap_pos >= limit_value_reg[stlt_pkg::LIM_Z_MAX]);
            stlt_pkg::LIM_Z_MAX:
                cap_ok = !(limit_on_reg[stlt_pkg::LIM_Z_MIN] &&
                           cap_pos <= limit_value_reg[stlt_pkg::LIM_Z_MIN]);
            stlt_pkg::LIM_X_MAX:
                cap_ok = !(limit_on_reg[stlt_pkg::LIM_X_MIN] &&
                           cap_pos <= limit_value_reg[stlt_pkg::LIM_X_MIN]);
            default:
                cap_ok = !(limit_on_reg[stlt_pkg::LIM_X_MAX] &&
                           cap_pos >= limit_value_reg[stlt_pkg::LIM_X_MAX]);
        endcase
    end

    assign min_idx = z_reg ? stlt_pkg::LIM_Z_MIN : stlt_pkg::LIM_X_MIN;
    assign max_idx = z_reg ? stlt_pkg::LIM_Z_MAX : stlt_pkg::LIM_X_MAX;
    assign set_idx = is_max_reg ? max_idx : min_idx;

    // Command update
    always_comb
    begin
        limit_on_next = limit_on_reg;
        for (int i = 0; i < 4; i++)
        begin
            limit_value_next[i] = limit_value_reg[i];
        end
        accepted_next = 1'b1;
        unique case (kind_reg)
            stlt_pkg::KIND_TOGGLE:
            begin
                if (limit_on_reg[idx_reg])
                begin
                    limit_on_next[idx_reg] = 1'b0;
                end
                else if (cap_ok)
                begin
                    limit_on_next[idx_reg]    = 1'b1;
                    limit_value_next[idx_reg] = cap_pos;
                end
                else
                begin
                    accepted_next = 1'b0;
                end
            end
            stlt_pkg::KIND_SET:
            begin
                limit_on_next[set_idx]    = 1'b1;
                limit_value_next[set_idx] = val_p;
            end
            stlt_pkg::KIND_REBASE:
            begin
                // Z limits sit at even slots, X limits at odd ones
                for (int i = 0; i < 4; i++)
                begin
                    if (limit_on_reg[i] && ((i % 2 == 0) == z_reg))
                    begin
                        limit_value_next[i] = limit_value_reg[i] - val_p;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Reports from the updated state
    assign val_cw = to_cw(val_p);
    assign xp_cw  = to_cw(xp_p);
    assign zp_cw  = to_cw(zp_p);

    assign x_min_cw = limit_on_next[stlt_pkg::LIM_X_MIN]
                      ? to_cw(limit_value_next[stlt_pkg::LIM_X_MIN]) : OFF_MIN_W;
    assign x_max_cw = limit_on_next[stlt_pkg::LIM_X_MAX]
                      ? to_cw(limit_value_next[stlt_pkg::LIM_X_MAX]) : OFF_MAX_W;
    assign z_min_cw = limit_on_next[stlt_pkg::LIM_Z_MIN]
                      ? to_cw(limit_value_next[stlt_pkg::LIM_Z_MIN]) : OFF_MIN_W;
    assign z_max_cw = limit_on_next[stlt_pkg::LIM_Z_MAX]
                      ? to_cw(limit_value_next[stlt_pkg::LIM_Z_MAX]) : OFF_MAX_W;

    assign in_range_next = (xp_cw >= x_min_cw) && (xp_cw <= x_max_cw) &&
                           (zp_cw >= z_min_cw) && (zp_cw <= z_max_cw);

    assign mn_cw = z_reg ? z_min_cw : x_min_cw;
    assign mx_cw = z_reg ? z_max_cw : x_max_cw;
    // Minimum is tested first: on crossed bounds a value below it gets the minimum, any other the maximum
    assign clamped_cw = (val_cw < mn_cw) ? mn_cw : ((val_cw > mx_cw) ? mx_cw : val_cw);

    assign apos = z_reg ? zp_p : xp_p;

    always_comb
    begin
        marker_next = stlt_pkg::MARK_NONE;
        if (!z_reg)
        begin
            if (limit_on_next[stlt_pkg::LIM_X_MIN] &&
                apos == limit_value_next[stlt_pkg::LIM_X_MIN])
            begin
                marker_next = stlt_pkg::MARK_X_REAR;
            end
            else if (limit_on_next[stlt_pkg::LIM_X_MAX] &&
                     apos == limit_value_next[stlt_pkg::LIM_X_MAX])
            begin
                marker_next = stlt_pkg::MARK_X_FRONT;
            end
        end
        else
        begin
            if (limit_on_next[stlt_pkg::LIM_Z_MIN] &&
                apos == limit_value_next[stlt_pkg::LIM_Z_MIN])
            begin
                marker_next = stlt_pkg::MARK_Z_LEFT;
            end
            else if (limit_on_next[stlt_pkg::LIM_Z_MAX] &&
                     apos == limit_value_next[stlt_pkg::LIM_Z_MAX])
            begin
                marker_next = stlt_pkg::MARK_Z_RIGHT;
            end
        end
    end

    assign index_cw = to_cw(limit_value_next[idx_reg]);

    // Go-to-limit: +1 heads for the maximum, any negative code for the minimum
    assign dir_up = (dir_reg == 2'sb01);

    always_comb
    begin
        dir_index_next = 2'd0;
        dtgt_p         = '0;
        dir_ok_next    = 1'b0;
        if (dir_reg != 2'sb00)
        begin
            dir_index_next = dir_up ? max_idx : min_idx;
            dtgt_p         = limit_value_next[dir_index_next];
            if (limit_on_next[dir_index_next])
            begin
                dir_ok_next = dir_up ? (apos < dtgt_p) : (apos > dtgt_p);
            end
        end
    end

    assign dtgt_cw = to_cw(dtgt_p);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            done_reg     <= 1'b0;
            limit_on_reg <= '0;
            for (int i = 0; i < 4; i++)
            begin
                limit_value_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg <= start && !busy;
            done_reg  <= valid_reg;
            if (valid_reg)
            begin
                limit_on_reg <= limit_on_next;
                for (int i = 0; i < 4; i++)
                begin
                    limit_value_reg[i] <= limit_value_next[i];
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            kind_reg    <= stlt_pkg::kind_t'(kind);
            idx_reg     <= limit_index;
            z_reg       <= axis_select;
            is_max_reg  <= is_max;
            val_in_reg  <= position_value;
            xp_in_reg   <= x_position;
            zp_in_reg   <= z_position;
            dir_reg     <= direction;
        end
        if (valid_reg)
        begin
            accepted_reg     <= accepted_next;
            led_mask_reg     <= limit_on_next;
            in_range_reg     <= in_range_next;
            clamped_reg      <= clamped_cw[31:0];
            axis_min_reg     <= mn_cw[31:0];
            axis_max_reg     <= mx_cw[31:0];
            any_active_reg   <= limit_on_next[min_idx] || limit_on_next[max_idx];
            marker_reg       <= marker_next;
            index_target_reg <= index_cw[31:0];
            dir_ok_reg       <= dir_ok_next;
            dir_index_reg    <= dir_index_next;
            dir_target_reg   <= dtgt_cw[31:0];
        end
    end

    assign done            = done_reg;
    assign accepted        = accepted_reg;
    assign led_mask        = led_mask_reg;
    assign in_range        = in_range_reg;
    assign clamped_target  = clamped_reg;
    assign axis_min        = axis_min_reg;
    assign axis_max        = axis_max_reg;
    assign axis_any_active = any_active_reg;
    assign marker          = marker_reg;
    assign index_target    = index_target_reg;
    assign dir_ok          = dir_ok_reg;
    assign dir_index       = dir_index_reg;
    assign dir_target      = dir_target_reg;

    `STLT_ASSERT_NXT(a_taken_goes_through, clk, rst_n, start && !busy, ##1 done,
        "accepted item did not produce a result two cycles later")
    `STLT_ASSERT_NXT(a_no_stray_result, clk, rst_n, !valid_reg, !done,
        "result strobe without an item in the input register")
    `STLT_ASSERT_IMP(a_leds_track_state, clk, rst_n, done, led_mask == limit_on_reg,
        "LED mask differs from the stored on flags")
    `STLT_ASSERT_NXT(a_refused_toggle_holds, clk, rst_n,
        valid_reg && kind_reg == stlt_pkg::KIND_TOGGLE && !accepted_next,
        $stable(limit_on_reg),
        "refused toggle changed the on flags")
    `STLT_ASSERT_IMP(a_dir_ok_needs_on, clk, rst_n, done && dir_ok,
        limit_on_reg[dir_index],
        "go-to-limit reported for a limit that is off")

endmodule
